// ===== src/arbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_pkg
// Shared types, register indexes and Booth partial product helpers for the
// approximate radix-4 Booth multiplier.
// ----------------------------------------------------------------------------
package arbm_pkg;

  localparam int OP_W        = 16;
  localparam int PROD_W      = 32;
  localparam int NUM_DIGITS  = OP_W / 2;
  localparam int COL_W       = 5;
  localparam int IDX_W       = 2;
  localparam int CFG_DATA_W  = COL_W;
  localparam int SUM1_N      = NUM_DIGITS / 2;
  localparam int SUM2_N      = NUM_DIGITS / 4;

  // Register indexes on the write port
  localparam logic [IDX_W-1:0] REG_APPROX_COLUMNS = 2'd0;
  localparam logic [IDX_W-1:0] REG_VARIANT        = 2'd1;

  // Reset values of the configuration registers
  localparam logic [COL_W-1:0] APPROX_COLUMNS_RST = 5'd14;
  localparam logic             VARIANT_RST        = 1'b1;

  // Approximation variants
  localparam logic VARIANT_ZERO2  = 1'b0;
  localparam logic VARIANT_INVERT = 1'b1;

  typedef logic [PROD_W-1:0] word_t;
  typedef logic [NUM_DIGITS-1:0][PROD_W-1:0] pp_vec_t;
  typedef logic [SUM1_N-1:0][PROD_W-1:0] sum1_vec_t;
  typedef logic [SUM2_N-1:0][PROD_W-1:0] sum2_vec_t;

  typedef struct packed {
    logic [COL_W-1:0] approx_columns;
    logic             variant;
  } cfg_t;

  // Digit scale per Booth group code, exact and with two-times digits dropped
  localparam logic signed [2:0] EXACT_SCALE [8] = '{
    3'sd0, 3'sd1, 3'sd1, 3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd0
  };
  localparam logic signed [2:0] ZERO2_SCALE [8] = '{
    3'sd0, 3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd1, -3'sd1, 3'sd0
  };
  // Invert on the middle bit of the group, add one on its sign bit
  localparam logic INV_BIT [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic ADD_BIT [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  // Scale a sign-extended multiplicand by a digit in -2..2
  function automatic word_t scale_word(input word_t yw, input logic signed [2:0] s);
    word_t r;
    begin
      case (s)
        3'sd1:   r = yw;
        -3'sd1:  r = -yw;
        3'sd2:   r = yw << 1;
        -3'sd2:  r = -(yw << 1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Partial product of one digit, already weighted by its position
  function automatic word_t booth_pp(input logic [2:0] code, input word_t yw,
                                     input cfg_t cfg, input int pos);
    logic signed [COL_W+1:0] sh;
    word_t mask;
    word_t ex;
    word_t ap;
    word_t pp;
    begin
      sh = $signed({2'b00, cfg.approx_columns}) - (COL_W+2)'(2 * pos);
      mask = (sh <= 0) ? '1 : ('1 << sh[COL_W-1:0]);
      ex = scale_word(yw, EXACT_SCALE[code]);
      if (cfg.variant == VARIANT_ZERO2) begin
        ap = scale_word(yw, ZERO2_SCALE[code]);
      end else begin
        ap = (yw ^ {PROD_W{INV_BIT[code]}}) + word_t'(ADD_BIT[code]);
      end
      pp = (ex & mask) | (ap & ~mask);
      return pp << (2 * pos);
    end
  endfunction

endpackage

// ===== src/arbm_ppgen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_ppgen
// Booth recoding and generation of the eight weighted partial products,
// exact above the column boundary and approximate below it.
// ----------------------------------------------------------------------------
module arbm_ppgen (
  input  logic [arbm_pkg::OP_W-1:0] x,
  input  logic [arbm_pkg::OP_W-1:0] y,
  input  arbm_pkg::cfg_t            cfg,
  output arbm_pkg::pp_vec_t         pp
);
  import arbm_pkg::*;

  logic [OP_W:0] ext;
  word_t         yw;

  // Append the implicit zero below bit 0 and sign-extend the multiplicand
  assign ext = {x, 1'b0};
  assign yw  = {{(PROD_W-OP_W){y[OP_W-1]}}, y};

  // Build one partial product per digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      pp[i] = booth_pp(ext[2*i +: 3], yw, cfg, i);
    end
  end

endmodule

// ===== src/approximate_radix4_booth_multiplier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approximate_radix4_booth_multiplier
// Signed 16 x 16 approximate radix-4 Booth multiplier, 32-bit wrapping
// product, four-stage pipeline.
//
//   channel  handshake        payload
//   -------  ---------------  -----------------------------
//   in       start, busy      multiplier, multiplicand
//   out      done             product
//   config   wr_en            wr_index, wr_data
//
// One beat is accepted every cycle; busy is always low. The product appears
// on done after the partial product stage and the three levels of the
// adder tree. Reset clears the valid bits and sets approx_columns to 14
// and variant to 1. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module approximate_radix4_booth_multiplier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [arbm_pkg::OP_W-1:0]   multiplier,
  input  logic signed [arbm_pkg::OP_W-1:0]   multiplicand,
  output logic                            done,
  output logic signed [arbm_pkg::PROD_W-1:0] product,
  input  logic                            wr_en,
  input  logic [arbm_pkg::IDX_W-1:0]      wr_index,
  input  logic [arbm_pkg::CFG_DATA_W-1:0] wr_data
);
  import arbm_pkg::*;

  cfg_t      cfg;
  pp_vec_t   pp_next;
  pp_vec_t   pp;
  sum1_vec_t sum1;
  sum2_vec_t sum2;
  logic      v1;
  logic      v2;
  logic      v3;

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.approx_columns <= APPROX_COLUMNS_RST;
      cfg.variant        <= VARIANT_RST;
    end else if (wr_en) begin
      if (wr_index == REG_APPROX_COLUMNS) begin
        cfg.approx_columns <= wr_data;
      end else if (wr_index == REG_VARIANT) begin
        cfg.variant <= wr_data[0];
      end
    end
  end

  arbm_ppgen u_ppgen (
    .x   (multiplier),
    .y   (multiplicand),
    .cfg (cfg),
    .pp  (pp_next)
  );

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Partial products, then a three-level adder tree
  always_ff @(posedge clk) begin
    pp <= pp_next;
    for (int i = 0; i < SUM1_N; i++) begin
      sum1[i] <= pp[2*i] + pp[2*i+1];
    end
    for (int i = 0; i < SUM2_N; i++) begin
      sum2[i] <= sum1[2*i] + sum1[2*i+1];
    end
    product <= sum2[0] + sum2[1];
  end

endmodule

// ===== src/arbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_checker
// Port-level checks on the multiplier: fixed latency and no stalls.
// ----------------------------------------------------------------------------
module arbm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import arbm_pkg::*;

  // Every accepted beat gives a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat gave no result after four cycles");

  // No result on done without an earlier matching beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without a matching beat");

  // The pipeline never holds off the sender
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  // Drop all results in flight on reset
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result straight after reset");

endmodule

bind approximate_radix4_booth_multiplier arbm_checker u_arbm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
